[sv/vtcs_pkg.sv]
// Shared types, widths and constants for the visual target chase steering block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package vtcs_pkg;

  // Defaults for the top-level parameters.
  localparam int FRAME_CENTER_X_DEF = 160;
  localparam int VOTE_WINDOW_DEF    = 5;
  localparam int VOTE_REQUIRED_DEF  = 3;
  localparam int LOST_HOLD_DEF      = 5;
  localparam int CLASS_COUNT_DEF    = 7;

  // Field and datapath widths.
  localparam int COORD_W    = 10;
  localparam int CLASS_W    = 4;
  localparam int MASK_W     = 7;
  localparam int STOP_W     = 10;
  localparam int CENTER_W   = 11;
  localparam int SPEED_W    = 16;
  localparam int DIR_W      = 17;
  localparam int ACC_W      = 26;
  localparam int DROP_W     = 14;
  localparam int LOST_W     = 4;
  localparam int DIV_NUM_W  = 26;
  localparam int DIV_DEN_W  = 11;
  localparam int DIV_CNT_W  = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  // Fixed-point constants (speeds are in units times 256, direction is Q1.15).
  localparam int BASE_FULL   = 16640;
  localparam int DROP_SPAN   = 5120;
  localparam int DIR_ONE     = 32768;
  localparam int EMA_NEW_WT  = 90;
  localparam int EMA_OLD_WT  = 166;
  localparam int EMA_ROUND   = 128;
  localparam int EMA_SHIFT   = 8;
  localparam int TURN_MUL    = 15;
  localparam int TURN_ROUND  = 16;
  localparam int TURN_SHIFT  = 5;
  localparam int STOP_RESET  = 120;
  localparam int MASK_RESET  = 127;
  localparam int LOST_MAX    = 15;

  typedef enum logic [1:0] {
    OUTCOME_STEER   = 2'd0,
    OUTCOME_LOST    = 2'd1,
    OUTCOME_REACHED = 2'd2
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STOP_HEIGHT = 1'b0,
    CFG_ACCEPT_MASK = 1'b1
  } cfg_reg_t;

  // Best box of the current frame.
  typedef struct packed {
    logic                found;
    logic [CENTER_W-1:0] key;
    logic [CENTER_W-1:0] center_twice;
    logic [COORD_W-1:0]  height;
    logic [CLASS_W-1:0]  cls;
  } best_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] numer;
    logic [DIV_DEN_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

[sv/vtcs_if.sv]
// Valid/ready channel interfaces for box beats in and motor command beats out.
// Depends on vtcs_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface vtcs_in_if;
  import vtcs_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [COORD_W-1:0] x_left;
  logic [COORD_W-1:0] x_right;
  logic [COORD_W-1:0] y_top;
  logic [COORD_W-1:0] y_bottom;
  logic [CLASS_W-1:0] box_class;

  modport source (
    output valid, kind, x_left, x_right, y_top, y_bottom, box_class,
    input  ready
  );

  modport sink (
    input  valid, kind, x_left, x_right, y_top, y_bottom, box_class,
    output ready
  );
endinterface

interface vtcs_out_if;
  import vtcs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] left_speed;
  logic signed [SPEED_W-1:0] right_speed;
  logic [1:0]                outcome;
  logic [CLASS_W-1:0]        reached_class;

  modport source (
    output valid, left_speed, right_speed, outcome, reached_class,
    input  ready
  );

  modport sink (
    input  valid, left_speed, right_speed, outcome, reached_class,
    output ready
  );
endinterface

`default_nettype wire

[sv/vtcs_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on vtcs_pkg for the request and response structs.
`timescale 1ns / 1ps
`default_nettype none

module vtcs_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire vtcs_pkg::div_req_t  req,
  output vtcs_pkg::div_rsp_t       rsp
);
  import vtcs_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;

  logic [DIV_DEN_W:0]   rem_sh;
  logic                 fits;

  // Shift in the next numerator bit and try to subtract the divisor.
  assign rem_sh = {rem_r, quo_r[DIV_NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= req.numer;
        rem_r  <= '0;
        den_r  <= req.denom;
      end else if (busy_r) begin
        quo_r <= {quo_r[DIV_NUM_W-2:0], fits};
        rem_r <= fits ? DIV_DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DEN_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

`default_nettype wire

[sv/vtcs_box.sv]
// Per-frame best-box tracker: class filter and closest-to-center selection.
// Depends on vtcs_pkg for widths and the best_t struct.
`timescale 1ns / 1ps
`default_nettype none

module vtcs_box #(
  parameter int FRAME_CENTER_X = vtcs_pkg::FRAME_CENTER_X_DEF,
  parameter int CLASS_COUNT    = vtcs_pkg::CLASS_COUNT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         take,
  input  wire logic                         clear,
  input  wire logic [vtcs_pkg::MASK_W-1:0]  accept_mask,
  input  wire logic [vtcs_pkg::COORD_W-1:0] x_left,
  input  wire logic [vtcs_pkg::COORD_W-1:0] x_right,
  input  wire logic [vtcs_pkg::COORD_W-1:0] y_top,
  input  wire logic [vtcs_pkg::COORD_W-1:0] y_bottom,
  input  wire logic [vtcs_pkg::CLASS_W-1:0] box_class,
  output vtcs_pkg::best_t                   best
);
  import vtcs_pkg::*;

  localparam logic [CENTER_W-1:0] TWICE = CENTER_W'(2 * FRAME_CENTER_X);

  best_t               best_r;
  logic [CENTER_W-1:0] c2;
  logic [CENTER_W-1:0] abs_off;
  logic [CENTER_W-1:0] key;
  logic [COORD_W-1:0]  height;
  logic [MASK_W:0]     mask_ext;
  logic                class_ok;
  logic                better;

  assign c2       = {1'b0, x_left} + {1'b0, x_right};
  assign abs_off  = (c2 >= TWICE) ? c2 - TWICE : TWICE - c2;
  assign key      = (abs_off > TWICE) ? TWICE : abs_off;
  assign height   = (y_bottom >= y_top) ? y_bottom - y_top : y_top - y_bottom;
  assign mask_ext = {1'b0, accept_mask};
  // Classes at or beyond the mask width are never chased.
  assign class_ok = (box_class < CLASS_COUNT) && !box_class[CLASS_W-1] &&
                    mask_ext[box_class[CLASS_W-2:0]];
  assign better   = !best_r.found || (key < best_r.key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r.found <= 1'b0;
    end else if (clear) begin
      best_r.found <= 1'b0;
    end else if (take && class_ok && better) begin
      best_r <= '{found: 1'b1, key: key, center_twice: c2, height: height,
                  cls: box_class};
    end
  end

  assign best = best_r;

endmodule

`default_nettype wire

[sv/visual_target_chase_steering.sv]
// Top level of the visual target chase steering block: sequencer, chase state,
// configuration registers and output register. Depends on vtcs_pkg, vtcs_if,
// vtcs_box and vtcs_div.
//
//   channel   direction  beat contents                                 handshake
//   in_ch     in         kind, x_left, x_right, y_top, y_bottom, class valid/ready
//   out_ch    out        left_speed, right_speed, outcome, reached_cls valid/ready
//   cfg_*     in         cfg_index, cfg_wdata                          cfg_we
//
// A detection box beat does not leave the idle state, so boxes can stream back to back.
// An end-of-frame beat with no usable box passes through S_DRIVE to S_EMIT
// (straight to S_EMIT when the chase aborts); its command is loaded as S_EMIT is
// left, and in_ch.ready returns at that edge. With a box, the sequence is S_DIV_RAW,
// S_EMA once the direction is seeded, S_VOTE, S_DIV_BASE, S_DRIVE and S_EMIT: the
// shared 26-step divider runs once for the steering direction and once for the speed
// ramp. A reached target or a zero stop height skips the second divide.
// Reset is synchronous and active low; afterwards stop_height is 120 and every
// class is enabled. While a frame end is being worked on in_ch.ready is low;
// a stalled out_ch only holds the block when the next command is complete.
`timescale 1ns / 1ps
`default_nettype none

module visual_target_chase_steering #(
  parameter int FRAME_CENTER_X = vtcs_pkg::FRAME_CENTER_X_DEF,
  parameter int VOTE_WINDOW    = vtcs_pkg::VOTE_WINDOW_DEF,
  parameter int VOTE_REQUIRED  = vtcs_pkg::VOTE_REQUIRED_DEF,
  parameter int LOST_HOLD      = vtcs_pkg::LOST_HOLD_DEF,
  parameter int CLASS_COUNT    = vtcs_pkg::CLASS_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  vtcs_in_if.sink                              in_ch,
  vtcs_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [vtcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vtcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import vtcs_pkg::*;

  localparam logic [CENTER_W-1:0] TWICE = CENTER_W'(2 * FRAME_CENTER_X);
  // Vote ring index and fill count widths.
  localparam int VPW = (VOTE_WINDOW > 1) ? $clog2(VOTE_WINDOW) : 1;
  localparam int FW  = $clog2(VOTE_WINDOW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_RAW,
    S_EMA,
    S_VOTE,
    S_DIV_BASE,
    S_DRIVE,
    S_EMIT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [STOP_W-1:0] stop_r;
  logic [MASK_W-1:0] mask_r;

  // Chase state.
  logic signed [DIR_W-1:0] s_r;
  logic                    seeded_r;
  logic [LOST_W-1:0]       lost_r;
  logic [VOTE_WINDOW-1:0]  ring_r;
  logic [VPW-1:0]          pos_r;
  logic [FW-1:0]           fill_r;

  // Working registers of the frame-end sequence.
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [DROP_W-1:0] drop_r;
  logic signed [SPEED_W-1:0] res_left_r;
  logic signed [SPEED_W-1:0] res_right_r;
  outcome_t                  res_outcome_r;
  logic [CLASS_W-1:0]        res_class_r;

  // Output register.
  logic                      out_valid_r;
  logic signed [SPEED_W-1:0] out_left_r;
  logic signed [SPEED_W-1:0] out_right_r;
  outcome_t                  out_outcome_r;
  logic [CLASS_W-1:0]        out_class_r;

  best_t    best;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_take;
  logic eof_take;
  logic box_take;
  logic emit_go;

  logic signed [DIR_W-1:0]   q_w;
  logic signed [DIR_W-1:0]   raw_w;
  logic signed [ACC_W-1:0]   ema_sum_w;
  logic signed [SPEED_W-1:0] turn_w;
  logic signed [SPEED_W-1:0] base_w;
  logic [COORD_W-1:0]        t_w;
  logic                      hit_w;
  logic                      reached_w;

  logic [VOTE_WINDOW-1:0] ring_nxt;
  logic [VOTE_WINDOW-1:0] fill_mask;
  logic [VPW-1:0]         pos_nxt;
  logic [FW-1:0]          fill_nxt;
  logic [FW-1:0]          hits_w;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign eof_take    = in_take && in_ch.kind;
  assign box_take    = in_take && !in_ch.kind;
  // The finished command moves to the output register once that is free.
  assign emit_go     = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  vtcs_box #(
    .FRAME_CENTER_X (FRAME_CENTER_X),
    .CLASS_COUNT    (CLASS_COUNT)
  ) u_box (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (box_take),
    .clear       (emit_go),
    .accept_mask (mask_r),
    .x_left      (in_ch.x_left),
    .x_right     (in_ch.x_right),
    .y_top       (in_ch.y_top),
    .y_bottom    (in_ch.y_bottom),
    .box_class   (in_ch.box_class),
    .best        (best)
  );

  vtcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Height vote and speed ramp operands.
  assign t_w   = (best.height < stop_r) ? best.height : stop_r;
  assign hit_w = best.height >= stop_r;

  // The divider serves two jobs: the direction quotient when a frame ends with
  // a box, and the speed ramp after the vote when the target is not yet reached.
  always_comb begin
    div_req.start = 1'b0;
    div_req.numer = DIV_NUM_W'(DROP_SPAN * t_w + (stop_r >> 1));
    div_req.denom = {1'b0, stop_r};
    if (state_r == S_IDLE) begin
      div_req.start = eof_take && best.found;
      div_req.numer = DIV_NUM_W'(best.key * DIR_ONE + FRAME_CENTER_X);
      div_req.denom = TWICE;
    end else if (state_r == S_VOTE) begin
      div_req.start = !reached_w && (stop_r != '0);
    end
  end

  // Raw direction: the quotient never exceeds one in Q1.15, and its sign comes
  // from which side of the center the box lies on.
  assign q_w   = signed'({1'b0, div_rsp.quot[DIR_W-2:0]});
  assign raw_w = (best.center_twice < TWICE) ? -q_w : q_w;

  assign ema_sum_w = ACC_W'(acc_r + s_r * EMA_OLD_WT + EMA_ROUND);
  assign turn_w    = SPEED_W'((s_r * TURN_MUL + TURN_ROUND) >>> TURN_SHIFT);
  assign base_w    = SPEED_W'(BASE_FULL - drop_r);

  // Vote ring after this frame's entry; only filled entries are counted.
  always_comb begin
    ring_nxt         = ring_r;
    ring_nxt[pos_r]  = hit_w;
    pos_nxt          = (pos_r == VPW'(VOTE_WINDOW - 1)) ? '0 : pos_r + 1'b1;
    fill_nxt         = (fill_r == FW'(VOTE_WINDOW)) ? fill_r : fill_r + 1'b1;
    for (int i = 0; i < VOTE_WINDOW; i++) begin
      fill_mask[i] = (i < fill_nxt);
    end
    hits_w = FW'($countones(ring_nxt & fill_mask));
  end

  assign reached_w = hits_w >= VOTE_REQUIRED;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r <= STOP_W'(STOP_RESET);
      mask_r <= MASK_W'(MASK_RESET);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_STOP_HEIGHT: stop_r <= cfg_wdata[STOP_W-1:0];
        CFG_ACCEPT_MASK: mask_r <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame-end sequencer, chase state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      s_r         <= '0;
      seeded_r    <= 1'b0;
      lost_r      <= '0;
      ring_r      <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A beat taken downstream empties the output register unless a new
      // command moves in at the same edge.
      if (out_ch.ready && !emit_go) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (eof_take) begin
            if (best.found) begin
              lost_r  <= '0;
              state_r <= S_DIV_RAW;
            end else if (lost_r >= LOST_W'(LOST_HOLD)) begin
              // Lost for too long: abort and drop the chase.
              s_r           <= '0;
              seeded_r      <= 1'b0;
              lost_r        <= '0;
              ring_r        <= '0;
              pos_r         <= '0;
              fill_r        <= '0;
              res_left_r    <= '0;
              res_right_r   <= '0;
              res_outcome_r <= OUTCOME_LOST;
              res_class_r   <= '0;
              state_r       <= S_EMIT;
            end else begin
              // Keep driving at full base speed on the last direction.
              if (lost_r != LOST_W'(LOST_MAX)) begin
                lost_r <= lost_r + 1'b1;
              end
              drop_r  <= '0;
              state_r <= S_DRIVE;
            end
          end
        end

        S_DIV_RAW: begin
          if (div_rsp.done) begin
            seeded_r <= 1'b1;
            if (seeded_r) begin
              acc_r   <= ACC_W'(raw_w * EMA_NEW_WT);
              state_r <= S_EMA;
            end else begin
              s_r     <= raw_w;
              state_r <= S_VOTE;
            end
          end
        end

        S_EMA: begin
          s_r     <= ema_sum_w[EMA_SHIFT +: DIR_W];
          state_r <= S_VOTE;
        end

        S_VOTE: begin
          if (reached_w) begin
            s_r           <= '0;
            seeded_r      <= 1'b0;
            lost_r        <= '0;
            ring_r        <= '0;
            pos_r         <= '0;
            fill_r        <= '0;
            res_left_r    <= '0;
            res_right_r   <= '0;
            res_outcome_r <= OUTCOME_REACHED;
            res_class_r   <= best.cls;
            state_r       <= S_EMIT;
          end else begin
            ring_r <= ring_nxt;
            pos_r  <= pos_nxt;
            fill_r <= fill_nxt;
            if (stop_r == '0) begin
              // Every height counts as close: crawl at the lowest speed.
              drop_r  <= DROP_W'(DROP_SPAN);
              state_r <= S_DRIVE;
            end else begin
              state_r <= S_DIV_BASE;
            end
          end
        end

        S_DIV_BASE: begin
          if (div_rsp.done) begin
            drop_r  <= signed'(DROP_W'(div_rsp.quot));
            state_r <= S_DRIVE;
          end
        end

        S_DRIVE: begin
          res_left_r    <= SPEED_W'(base_w + turn_w);
          res_right_r   <= SPEED_W'(base_w - turn_w);
          res_outcome_r <= OUTCOME_STEER;
          res_class_r   <= '0;
          state_r       <= S_EMIT;
        end

        S_EMIT: begin
          if (emit_go) begin
            out_valid_r   <= 1'b1;
            out_left_r    <= res_left_r;
            out_right_r   <= res_right_r;
            out_outcome_r <= res_outcome_r;
            out_class_r   <= res_class_r;
            state_r       <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.left_speed    = out_left_r;
  assign out_ch.right_speed   = out_right_r;
  assign out_ch.outcome       = out_outcome_r;
  assign out_ch.reached_class = out_class_r;

endmodule

`default_nettype wire
